// ===== design/friction_cone_projection_top_assert.svh =====
// Assertion helpers shared by the friction cone projection RTL.
`ifndef FRICTION_CONE_PROJECTION_TOP_ASSERT_SVH
`define FRICTION_CONE_PROJECTION_TOP_ASSERT_SVH

// Same-cycle implication.
`define FCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcp: implication check failed");

// Next-cycle implication.
`define FCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcp: next-cycle check failed");

`endif

// ===== design/fcp_pkg.sv =====
`default_nettype none
package fcp_pkg;

  localparam int MAG_W   = 31;   // magnitude of a Q16.16 value after clamping
  localparam int SQ_W    = 63;   // a*a + b*b
  localparam int ROOT_W  = 32;
  localparam int NUM_W   = 62;   // |v| * bound
  localparam int MU_FRAC = 12;
  localparam logic [MAG_W-1:0] Q_MAX = '1;

  typedef struct packed {
    logic signed [31:0] normal_impulse;
    logic signed [31:0] friction_a;
    logic signed [31:0] friction_b;
    logic        [15:0] friction_coeff;
  } fcp_in_t;

  typedef struct packed {
    logic        [30:0] normal_out;
    logic signed [31:0] friction_a_out;
    logic signed [31:0] friction_b_out;
    logic               circle_scaled;
  } fcp_out_t;

  // What travels alongside the square root and the division.
  typedef struct packed {
    logic [MAG_W-1:0] normal;
    logic [MAG_W-1:0] ua;
    logic [MAG_W-1:0] ub;
    logic             sa;
    logic             sb;
    logic [MAG_W-1:0] bound;
    logic             need;
  } fcp_ctx_t;

endpackage
`default_nettype wire

// ===== design/fcp_front.sv =====
`default_nettype none
module fcp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire fcp_pkg::fcp_in_t  in_item,
  input  wire logic [15:0]       min_normal,
  output logic                   s_valid,
  output logic [fcp_pkg::SQ_W-1:0] s_val,
  output fcp_pkg::fcp_ctx_t      s_ctx
);

  localparam int MW = fcp_pkg::MAG_W;

  // stage 1: clamp normal, absolute values
  logic          v1_r;
  logic [MW-1:0] n1_r;
  logic [31:0]   ua1_r, ub1_r;
  logic          sa1_r, sb1_r, small1_r;
  logic [15:0]   mu1_r;
  logic [MW-1:0] n1_nxt;
  logic [31:0]   ua1_nxt, ub1_nxt;

  always_comb begin
    n1_nxt  = in_item.normal_impulse[31] ? '0 : in_item.normal_impulse[MW-1:0];
    ua1_nxt = in_item.friction_a[31] ? 32'(-in_item.friction_a) : 32'(in_item.friction_a);
    ub1_nxt = in_item.friction_b[31] ? 32'(-in_item.friction_b) : 32'(in_item.friction_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
    end
    n1_r     <= n1_nxt;
    ua1_r    <= ua1_nxt;
    ub1_r    <= ub1_nxt;
    sa1_r    <= in_item.friction_a[31];
    sb1_r    <= in_item.friction_b[31];
    mu1_r    <= in_item.friction_coeff;
    small1_r <= n1_nxt < {15'b0, min_normal};
  end

  // stage 2: mu * normal
  logic          v2_r;
  logic [46:0]   prod2_r;
  logic [MW-1:0] n2_r;
  logic [31:0]   ua2_r, ub2_r;
  logic          sa2_r, sb2_r, small2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    prod2_r  <= {31'b0, mu1_r} * {16'b0, n1_r};
    n2_r     <= n1_r;
    ua2_r    <= ua1_r;
    ub2_r    <= ub1_r;
    sa2_r    <= sa1_r;
    sb2_r    <= sb1_r;
    small2_r <= small1_r;
  end

  // stage 3: saturated bound, symmetric clamp
  logic          v3_r;
  logic [MW-1:0] bound3_r, n3_r, ua3_r, ub3_r;
  logic          sa3_r, sb3_r;
  logic [34:0]   bnd_raw;
  logic [MW-1:0] bound3_nxt, ua3_nxt, ub3_nxt;

  always_comb begin
    bnd_raw    = prod2_r[46:fcp_pkg::MU_FRAC];
    bound3_nxt = (|bnd_raw[34:MW]) ? fcp_pkg::Q_MAX : bnd_raw[MW-1:0];
    ua3_nxt    = (ua2_r > {1'b0, bound3_nxt}) ? bound3_nxt : ua2_r[MW-1:0];
    ub3_nxt    = (ub2_r > {1'b0, bound3_nxt}) ? bound3_nxt : ub2_r[MW-1:0];
    if (small2_r) begin
      ua3_nxt = '0;
      ub3_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    bound3_r <= bound3_nxt;
    n3_r     <= n2_r;
    ua3_r    <= ua3_nxt;
    ub3_r    <= ub3_nxt;
    sa3_r    <= sa2_r;
    sb3_r    <= sb2_r;
  end

  // stage 4: squares
  logic          v4_r;
  logic [61:0]   sqa4_r, sqb4_r, bb4_r;
  logic [MW-1:0] bound4_r, n4_r, ua4_r, ub4_r;
  logic          sa4_r, sb4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    sqa4_r   <= {31'b0, ua3_r} * {31'b0, ua3_r};
    sqb4_r   <= {31'b0, ub3_r} * {31'b0, ub3_r};
    bb4_r    <= {31'b0, bound3_r} * {31'b0, bound3_r};
    bound4_r <= bound3_r;
    n4_r     <= n3_r;
    ua4_r    <= ua3_r;
    ub4_r    <= ub3_r;
    sa4_r    <= sa3_r;
    sb4_r    <= sb3_r;
  end

  // stage 5: length squared against bound squared
  logic                      v5_r;
  logic [fcp_pkg::SQ_W-1:0]  s5_r;
  fcp_pkg::fcp_ctx_t         ctx5_r;
  logic [fcp_pkg::SQ_W-1:0]  s5_nxt;

  assign s5_nxt = {1'b0, sqa4_r} + {1'b0, sqb4_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    s5_r          <= s5_nxt;
    ctx5_r.normal <= n4_r;
    ctx5_r.ua     <= ua4_r;
    ctx5_r.ub     <= ub4_r;
    ctx5_r.sa     <= sa4_r;
    ctx5_r.sb     <= sb4_r;
    ctx5_r.bound  <= bound4_r;
    ctx5_r.need   <= s5_nxt > {1'b0, bb4_r};
  end

  assign s_valid = v5_r;
  assign s_val   = s5_r;
  assign s_ctx   = ctx5_r;

endmodule
`default_nettype wire

// ===== design/fcp_sqrt.sv =====
`default_nettype none
module fcp_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [fcp_pkg::SQ_W-1:0]    in_s,
  input  wire fcp_pkg::fcp_ctx_t           in_ctx,
  output logic                             out_valid,
  output logic [fcp_pkg::ROOT_W-1:0]       out_root,
  output fcp_pkg::fcp_ctx_t                out_ctx
);

  localparam int RW = fcp_pkg::ROOT_W;
  localparam int XW = RW + 3;   // remainder with headroom for the two new bits

  logic                  v_r    [RW];
  logic [2*RW-1:0]       s_r    [RW];
  logic [XW-1:0]         rem_r  [RW];
  logic [RW-1:0]         root_r [RW];
  fcp_pkg::fcp_ctx_t     ctx_r  [RW];

  // one result bit per stage, most significant first
  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int J = RW - 1 - i;
    logic              v_in;
    logic [2*RW-1:0]   s_in;
    logic [XW-1:0]     rem_in, rem_sh, trial;
    logic [RW-1:0]     root_in;
    fcp_pkg::fcp_ctx_t ctx_in;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign s_in    = {1'b0, in_s};
      assign rem_in  = '0;
      assign root_in = '0;
      assign ctx_in  = in_ctx;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign s_in    = s_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign ctx_in  = ctx_r[i-1];
    end

    always_comb begin
      rem_sh = {rem_in[XW-3:0], s_in[2*J+1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
      s_r[i]    <= s_in;
      rem_r[i]  <= ge ? rem_sh - trial : rem_sh;
      root_r[i] <= {root_in[RW-2:0], ge};
      ctx_r[i]  <= ctx_in;
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_ctx   = ctx_r[RW-1];

endmodule
`default_nettype wire

// ===== design/fcp_div.sv =====
`default_nettype none
module fcp_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [fcp_pkg::NUM_W-1:0]   in_na,
  input  wire logic [fcp_pkg::NUM_W-1:0]   in_nb,
  input  wire logic [fcp_pkg::ROOT_W-1:0]  in_den,
  input  wire fcp_pkg::fcp_ctx_t           in_ctx,
  output logic                             out_valid,
  output logic [fcp_pkg::MAG_W-1:0]        out_qa,
  output logic [fcp_pkg::MAG_W-1:0]        out_qb,
  output fcp_pkg::fcp_ctx_t                out_ctx
);

  localparam int QW = fcp_pkg::MAG_W;
  localparam int DW = fcp_pkg::ROOT_W;
  localparam int NW = fcp_pkg::NUM_W;

  logic                  v_r   [QW];
  logic [NW-1:0]         na_r  [QW];
  logic [NW-1:0]         nb_r  [QW];
  logic [DW-1:0]         den_r [QW];
  logic [DW-1:0]         ra_r  [QW];
  logic [DW-1:0]         rb_r  [QW];
  logic [QW-1:0]         qa_r  [QW];
  logic [QW-1:0]         qb_r  [QW];
  fcp_pkg::fcp_ctx_t     ctx_r [QW];

  // restoring division, one quotient bit per stage on both lanes;
  // the quotient fits QW bits since |v| <= root
  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    logic              v_in;
    logic [NW-1:0]     na_in, nb_in;
    logic [DW-1:0]     den_in, ra_in, rb_in;
    logic [QW-1:0]     qa_in, qb_in;
    fcp_pkg::fcp_ctx_t ctx_in;
    logic [DW:0]       ra_sh, rb_sh;
    logic              ge_a, ge_b;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign na_in  = in_na;
      assign nb_in  = in_nb;
      assign den_in = in_den;
      assign ra_in  = {1'b0, in_na[NW-1:QW]};
      assign rb_in  = {1'b0, in_nb[NW-1:QW]};
      assign qa_in  = '0;
      assign qb_in  = '0;
      assign ctx_in = in_ctx;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign na_in  = na_r[i-1];
      assign nb_in  = nb_r[i-1];
      assign den_in = den_r[i-1];
      assign ra_in  = ra_r[i-1];
      assign rb_in  = rb_r[i-1];
      assign qa_in  = qa_r[i-1];
      assign qb_in  = qb_r[i-1];
      assign ctx_in = ctx_r[i-1];
    end

    always_comb begin
      ra_sh = {ra_in, na_in[K]};
      rb_sh = {rb_in, nb_in[K]};
      ge_a  = ra_sh >= {1'b0, den_in};
      ge_b  = rb_sh >= {1'b0, den_in};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
      na_r[i]  <= na_in;
      nb_r[i]  <= nb_in;
      den_r[i] <= den_in;
      ra_r[i]  <= ge_a ? DW'(ra_sh - {1'b0, den_in}) : ra_sh[DW-1:0];
      rb_r[i]  <= ge_b ? DW'(rb_sh - {1'b0, den_in}) : rb_sh[DW-1:0];
      qa_r[i]  <= {qa_in[QW-2:0], ge_a};
      qb_r[i]  <= {qb_in[QW-2:0], ge_b};
      ctx_r[i] <= ctx_in;
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_qa    = qa_r[QW-1];
  assign out_qb    = qb_r[QW-1];
  assign out_ctx   = ctx_r[QW-1];

endmodule
`default_nettype wire

// ===== design/friction_cone_projection_top.sv =====
// Friction cone projection for one contact per item.
// Input: drive start with in_item (normal, two friction impulses, mu);
// busy is always low, so an item is taken on every cycle start is high.
// Output: out_valid strobes for one cycle with out_item; there is no
// back-pressure, the receiver must take every result as it appears.
// Config: min_normal is written over cfg_valid/cfg_data (cfg_ready always
// high); write it only while no item is in flight.
// Throughput: one item per cycle, with no dependence between items.
// Pipeline: 5 front stages (clamp, mu*normal, bound and clamp, squares,
// length compare), a 32-stage square root, one product stage, a 31-stage
// two-lane divider and the output register.
// Reset: synchronous, clears all valid bits and sets min_normal to 1;
// the block is ready in the first cycle after reset.
`default_nettype none
`include "friction_cone_projection_top_assert.svh"
module friction_cone_projection_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire fcp_pkg::fcp_in_t  in_item,
  output logic                   out_valid,
  output fcp_pkg::fcp_out_t      out_item,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_data
);

  localparam int MW = fcp_pkg::MAG_W;

  logic [15:0] min_normal_r;
  logic        in_fire;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_normal_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      min_normal_r <= cfg_data;
    end
  end

  logic                          fr_v;
  logic [fcp_pkg::SQ_W-1:0]      fr_s;
  fcp_pkg::fcp_ctx_t             fr_ctx;

  fcp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_item    (in_item),
    .min_normal (min_normal_r),
    .s_valid    (fr_v),
    .s_val      (fr_s),
    .s_ctx      (fr_ctx)
  );

  logic                          sq_v;
  logic [fcp_pkg::ROOT_W-1:0]    sq_root;
  fcp_pkg::fcp_ctx_t             sq_ctx;

  fcp_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_v),
    .in_s      (fr_s),
    .in_ctx    (fr_ctx),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_ctx   (sq_ctx)
  );

  // |v| * bound for both lanes
  logic                          pm_v_r;
  logic [fcp_pkg::NUM_W-1:0]     pa_r, pb_r;
  logic [fcp_pkg::ROOT_W-1:0]    root_r;
  fcp_pkg::fcp_ctx_t             pm_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_v_r <= 1'b0;
    end else begin
      pm_v_r <= sq_v;
    end
    pa_r     <= {31'b0, sq_ctx.ua} * {31'b0, sq_ctx.bound};
    pb_r     <= {31'b0, sq_ctx.ub} * {31'b0, sq_ctx.bound};
    root_r   <= sq_root;
    pm_ctx_r <= sq_ctx;
  end

  logic                          dv_v;
  logic [MW-1:0]                 dv_qa, dv_qb;
  fcp_pkg::fcp_ctx_t             dv_ctx;

  fcp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pm_v_r),
    .in_na     (pa_r),
    .in_nb     (pb_r),
    .in_den    (root_r),
    .in_ctx    (pm_ctx_r),
    .out_valid (dv_v),
    .out_qa    (dv_qa),
    .out_qb    (dv_qb),
    .out_ctx   (dv_ctx)
  );

  logic              out_valid_r;
  fcp_pkg::fcp_out_t out_item_r, out_item_nxt;
  logic [MW-1:0]     mag_a, mag_b;

  always_comb begin
    mag_a = dv_ctx.need ? dv_qa : dv_ctx.ua;
    mag_b = dv_ctx.need ? dv_qb : dv_ctx.ub;
    out_item_nxt.normal_out     = dv_ctx.normal;
    out_item_nxt.friction_a_out = dv_ctx.sa ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
    out_item_nxt.friction_b_out = dv_ctx.sb ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});
    out_item_nxt.circle_scaled  = dv_ctx.need;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // scaled pair never leaves the bound; root is non-zero when scaling
  `FCP_ASSERT_IMP(a_qa_in_bound, dv_v && dv_ctx.need, dv_qa <= dv_ctx.bound)
  `FCP_ASSERT_IMP(a_qb_in_bound, dv_v && dv_ctx.need, dv_qb <= dv_ctx.bound)
  `FCP_ASSERT_IMP(a_root_nonzero, sq_v && sq_ctx.need, sq_root != '0)
  `FCP_ASSERT_NXT(a_out_follows, dv_v, out_valid)

endmodule
`default_nettype wire

// ===== bench/tb_friction_cone_projection_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_friction_cone_projection_top;

  localparam int LATENCY = 70;
  localparam longint LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  fcp_pkg::fcp_in_t in_item;
  logic out_valid;
  fcp_pkg::fcp_out_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  friction_cone_projection_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  typedef struct {
    fcp_pkg::fcp_in_t item;
    logic has_exp;
    fcp_pkg::fcp_out_t exp;
  } stim_row_t;

  fcp_pkg::fcp_out_t pending_results[$];
  logic [15:0] min_normal_shadow;
  int n_errors;
  longint cycle_cnt = 0;
  int idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > s) bit_v >>= 2;
    while (bit_v != 0) begin
      if (s >= root + bit_v) begin
        s -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic fcp_pkg::fcp_out_t project_cone(fcp_pkg::fcp_in_t it);
    fcp_pkg::fcp_out_t r;
    longint n, a, b;
    logic [63:0] bound, ua, ub, sq, mag, q;
    n = longint'(it.normal_impulse);
    a = longint'(it.friction_a);
    b = longint'(it.friction_b);
    r.circle_scaled = 1'b0;
    if (n < 0) n = 0;
    if (n < longint'(min_normal_shadow)) begin
      a = 0;
      b = 0;
    end else begin
      bound = (64'(it.friction_coeff) * 64'(n)) >> fcp_pkg::MU_FRAC;
      if (bound > 64'h7FFF_FFFF) bound = 64'h7FFF_FFFF;
      if (a > longint'(bound)) a = bound;
      if (a < -longint'(bound)) a = -longint'(bound);
      if (b > longint'(bound)) b = bound;
      if (b < -longint'(bound)) b = -longint'(bound);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      sq = ua * ua + ub * ub;
      if (sq > bound * bound) begin
        mag = int_sqrt(sq);
        if (mag != 0) begin
          q = (ua * bound) / mag;
          a = (a < 0) ? -longint'(q) : longint'(q);
          q = (ub * bound) / mag;
          b = (b < 0) ? -longint'(q) : longint'(q);
          r.circle_scaled = 1'b1;
        end
      end
    end
    r.normal_out = n[30:0];
    r.friction_a_out = a[31:0];
    r.friction_b_out = b[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    fcp_pkg::fcp_out_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_item.normal_out !== e.normal_out)
          report_mismatch("normal_out", 32'(out_item.normal_out), 32'(e.normal_out));
        if (out_item.friction_a_out !== e.friction_a_out)
          report_mismatch("friction_a_out", out_item.friction_a_out, e.friction_a_out);
        if (out_item.friction_b_out !== e.friction_b_out)
          report_mismatch("friction_b_out", out_item.friction_b_out, e.friction_b_out);
        if (out_item.circle_scaled !== e.circle_scaled)
          report_mismatch("circle_scaled", 32'(out_item.circle_scaled),
                          32'(e.circle_scaled));
      end
    end
  end

  // drive one item; start stays high into the next item unless idling
  task automatic send_item(fcp_pkg::fcp_in_t it, logic has_exp, fcp_pkg::fcp_out_t exp);
    fcp_pkg::fcp_out_t p;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    p = project_cone(it);
    if (has_exp && p !== exp) report_mismatch("table row vs predictor", 0, 0);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(p);
    @(negedge clk);
  endtask

  task automatic write_min_normal(logic [15:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_normal_shadow = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($urandom_range(65535)) << $urandom_range(16);
      2: return -(32'($urandom_range(65535)) << $urandom_range(16));
      3: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: return $urandom_range(1 << 20);
    endcase
  endfunction

  function automatic fcp_pkg::fcp_in_t rand_item();
    fcp_pkg::fcp_in_t it;
    it.normal_impulse = $urandom_range(9) == 0 ? $urandom : $urandom_range(32'h00FF_FFFF);
    if ($urandom_range(9) == 0) it.normal_impulse = $urandom_range(3);
    it.friction_a = rand_q();
    it.friction_b = rand_q();
    it.friction_coeff = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8192));
    return it;
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    int phase_pct[4] = '{0, 57, 0, 37};
    logic [15:0] min_settings[4] = '{16'd0, 16'hFFFF, 16'd300, 16'd1};
    n_errors = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    min_normal_shadow = 16'd1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // after reset (min 1): zero normal -> friction zeroed
    rows.push_back('{'{32'sd0, 32'sd5, -32'sd5, 16'd4096}, 1'b1, '{31'd0, 0, 0, 1'b0}});
    // negative normal clamps to zero
    rows.push_back('{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF}, 1'b1,
                     '{31'd0, 0, 0, 1'b0}});
    // mu 1.0, inside the cone
    rows.push_back('{'{32'sd65536, 32'sd100, -32'sd100, 16'd4096}, 1'b1,
                     '{31'd65536, 32'sd100, -32'sd100, 1'b0}});
    // mu 0: bound zero, friction clamps to zero
    rows.push_back('{'{32'sd65536, 32'sd7, 32'sd9, 16'd0}, 1'b1,
                     '{31'd65536, 0, 0, 1'b0}});
    // one axis clamped, no scaling
    rows.push_back('{'{32'sd65536, 32'sd200000, 32'sd0, 16'd4096}, 1'b1,
                     '{31'd65536, 32'sd65536, 32'sd0, 1'b0}});
    // bound saturates
    rows.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'sd0, 16'hFFFF}, 1'b1,
                     '{31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'sd0, 1'b0}});
    // predictor only: rows scaled onto circle, and one small pair that stays inside
    rows.push_back('{'{32'sd65536, 32'sd65536, 32'sd65536, 16'd4096}, 1'b0, '0});
    rows.push_back('{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'hFFFF}, 1'b0, '0});
    rows.push_back('{'{32'sd1, -32'sd1, 32'sd1, 16'hFFFF}, 1'b0, '0});
    rows.push_back('{'{32'sd1000, 32'sd3, -32'sd4, 16'd20}, 1'b0, '0});
    rows.push_back('{'{32'h0001_0000, -32'sd40000, 32'sd30000, 16'd2048}, 1'b0, '0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_exp, rows[i].exp);

    for (int ph = 0; ph < 4; ph++) begin
      write_min_normal(min_settings[ph]);
      idle_pct = phase_pct[ph];
      if (ph == 0) begin
        // zero minimum, zero normal
        r.item = '{32'sd0, -32'sd3, 32'sd3, 16'd4096};
        send_item(r.item, 1'b1, '{31'd0, 0, 0, 1'b0});
      end
      for (int i = 0; i < 275; i++) begin
        if (i % 60 < 15) idle_pct = 0;
        else idle_pct = phase_pct[ph];
        send_item(rand_item(), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
